/* src/pfs_pkg.sv */
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared widths, constants and beat types of the proportional fair scheduler.
// ----------------------------------------------------------------------------
package pfs_pkg;

  // field widths
  localparam int USER_W   = 3;
  localparam int SINR_W   = 16;
  localparam int METRIC_W = 16;
  localparam int ALPHA_W  = 9;

  // default number of users kept in the average store
  localparam int USER_COUNT_DEF = 8;

  // smoothing weight: 256 is 1.0, reset value 0.5
  localparam logic [ALPHA_W-1:0]  ALPHA_ONE   = 9'd256;
  localparam logic [ALPHA_W-1:0]  ALPHA_RESET = 9'd128;
  localparam logic [METRIC_W-1:0] METRIC_MAX  = 16'hFFFF;

  // queue depths
  localparam int WORK_Q_DEPTH = 2;
  localparam int OUT_Q_DEPTH  = 2;

  // one classified report between front and back
  typedef struct packed {
    logic [USER_W-1:0] user;
    logic [SINR_W-1:0] sinr;
    logic              in_range;
    logic              last;
  } work_t;

  // one slot decision
  typedef struct packed {
    logic [USER_W-1:0]   user;
    logic [METRIC_W-1:0] metric;
  } result_t;

endpackage

/* src/pfs_fifo.sv */
// ----------------------------------------------------------------------------
// pfs_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module pfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0] DEPTH_CNT = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wptr_r;
  logic [AW-1:0]    rptr_r;
  logic [AW:0]      count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == DEPTH_CNT);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rptr_r];

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* src/pfs_front.sv */
// ----------------------------------------------------------------------------
// pfs_front
// Input side: takes report beats, checks the user range and queues them.
// ----------------------------------------------------------------------------
module pfs_front #(
  parameter int USER_COUNT = pfs_pkg::USER_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [pfs_pkg::USER_W-1:0]  in_user_index,
  input  logic [pfs_pkg::SINR_W-1:0]  in_sinr_sample,
  input  logic                        in_slot_last,
  input  logic                        work_pop,
  output pfs_pkg::work_t              work_data,
  output logic                        work_empty
);

  import pfs_pkg::*;

  localparam logic [8:0] USER_LIMIT = 9'(USER_COUNT);

  work_t      entry;
  logic [8:0] user_wide;

  // classify the report: users past the store leave the averages and seen flags alone
  assign user_wide      = {6'd0, in_user_index};
  assign entry.user     = in_user_index;
  assign entry.sinr     = in_sinr_sample;
  assign entry.in_range = (user_wide < USER_LIMIT);
  assign entry.last     = in_slot_last;

  // queue toward the back end
  pfs_fifo #(
    .WIDTH ($bits(work_t)),
    .DEPTH (WORK_Q_DEPTH)
  ) u_work_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (entry),
    .full      (in_full),
    .pop       (work_pop),
    .pop_data  (work_data),
    .empty     (work_empty)
  );

endmodule

/* src/pfs_back.sv */
// ----------------------------------------------------------------------------
// pfs_back
// Back end: average update, radix-2 metric divider and slot maximum tracking.
// ----------------------------------------------------------------------------
module pfs_back #(
  parameter int USER_COUNT = pfs_pkg::USER_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [pfs_pkg::ALPHA_W-1:0]  alpha,
  output logic                         work_pop,
  input  pfs_pkg::work_t               work_data,
  input  logic                         work_empty,
  output logic                         res_push,
  output pfs_pkg::result_t             res_data,
  input  logic                         res_full
);

  import pfs_pkg::*;

  localparam int IDX_W = $clog2(USER_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL2,
    S_SUM,
    S_DIV,
    S_UPD,
    S_EMIT
  } state_t;

  state_t              state_r;
  logic [USER_W-1:0]   user_r;
  logic [IDX_W-1:0]    idx_r;
  logic [SINR_W-1:0]   sinr_r;
  logic                last_r;
  logic                cur_seen_r;
  logic [USER_COUNT-1:0] seen_r;
  logic [SINR_W-1:0]   avg_rd_r;
  logic [SINR_W-1:0]   avg_r;
  logic [24:0]         prod1_r;
  logic [24:0]         prod2_r;
  logic [SINR_W-1:0]   rem_r;
  logic [SINR_W-1:0]   dvd_r;
  logic [METRIC_W-1:0] quo_r;
  logic [3:0]          cnt_r;
  logic [METRIC_W-1:0] best_metric_r;
  logic [USER_W-1:0]   best_user_r;
  logic                have_best_r;
  logic [SINR_W-1:0]   avg_mem [USER_COUNT];

  logic [8:0]          head_wide;
  logic [IDX_W-1:0]    head_idx;
  logic [ALPHA_W-1:0]  alpha_sat;
  logic [ALPHA_W-1:0]  alpha_inv;
  logic [24:0]         avg_sum;
  logic [SINR_W-1:0]   avg_new;
  logic                metric_sat;
  logic                mem_rd;
  logic                mem_wr;
  logic [SINR_W:0]     trial;
  logic                trial_ge;

  // head of the work queue and store address
  assign head_wide = {6'd0, work_data.user};
  assign head_idx  = head_wide[IDX_W-1:0];
  assign work_pop  = (state_r == S_IDLE) && !work_empty;
  assign mem_rd    = work_pop && work_data.in_range;
  assign mem_wr    = (state_r == S_SUM);

  // weights, alpha above one counts as one
  assign alpha_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
  assign alpha_inv = ALPHA_ONE - alpha_sat;

  // new average: first report takes the sample itself
  assign avg_sum    = prod1_r + prod2_r;
  assign avg_new    = cur_seen_r ? avg_sum[23:8] : sinr_r;
  // quotient does not fit 16 bits (zero average included)
  assign metric_sat = ({8'd0, sinr_r} >= {avg_new, 8'd0});

  // one restoring divider step
  assign trial    = {rem_r, dvd_r[SINR_W-1]};
  assign trial_ge = (trial >= {1'b0, avg_r});

  // result beat
  assign res_push        = (state_r == S_EMIT) && !res_full;
  assign res_data.user   = best_user_r;
  assign res_data.metric = best_metric_r;

  // average store
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      avg_mem[idx_r] <= avg_new;
    end
    if (mem_rd) begin
      avg_rd_r <= avg_mem[head_idx];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      seen_r        <= '0;
      best_metric_r <= '0;
      best_user_r   <= '0;
      have_best_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (!work_empty) begin
            user_r     <= work_data.user;
            idx_r      <= head_idx;
            sinr_r     <= work_data.sinr;
            last_r     <= work_data.last;
            cur_seen_r <= seen_r[head_idx];
            if (work_data.in_range) begin
              state_r <= S_READ;
            end else if (work_data.last) begin
              state_r <= S_EMIT;
            end
          end
        end
        S_READ: begin
          prod1_r <= 25'(alpha_sat) * 25'(sinr_r);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod2_r <= 25'(alpha_inv) * 25'(avg_rd_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          seen_r[idx_r] <= 1'b1;
          avg_r         <= avg_new;
          if (metric_sat) begin
            quo_r   <= METRIC_MAX;
            state_r <= S_UPD;
          end else begin
            rem_r   <= {8'd0, sinr_r[15:8]};
            dvd_r   <= {sinr_r[7:0], 8'd0};
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= trial_ge ? 16'(trial - {1'b0, avg_r}) : trial[SINR_W-1:0];
          quo_r <= {quo_r[METRIC_W-2:0], trial_ge};
          dvd_r <= {dvd_r[SINR_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 4'd15) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (!have_best_r || (quo_r > best_metric_r)) begin
            best_metric_r <= quo_r;
            best_user_r   <= user_r;
            have_best_r   <= 1'b1;
          end
          state_r <= last_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!res_full) begin
            best_metric_r <= '0;
            best_user_r   <= '0;
            have_best_r   <= 1'b0;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/proportional_fair_scheduler.sv */
// ----------------------------------------------------------------------------
// proportional_fair_scheduler
// Per-user EWMA of SINR reports and slot-wise proportional fair user choice.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_push / in_full): one beat per user SINR report, Q8.8.
//   in_slot_last marks the last report of a slot; that beat yields one result.
//   Result channel (out_empty / out_pop): chosen user and its metric
//   sinr/avg in Q8.8, saturated to 65535; the oldest result sits on the
//   out_ ports while out_empty is low.
//   cfg_wr_en / cfg_wr_data write the smoothing weight (256 = 1.0); write it
//   only while the block is idle.
//   The back end takes a new report from the work queue only once it is done
//   with the last; a report that needs a division runs the 16-step radix-2
//   divider after the two sequential EWMA multiplies, a saturated metric skips
//   the divider, and a user out of range skips the average update.
//   A two-entry queue between front and back takes reports while the back
//   end works. When the receiver stalls, up to two results wait in the output
//   queue; after that the back end holds, the work queue fills and in_full
//   rises. Reset empties both queues, clears all seen flags and the running
//   maximum, and sets the weight to 0.5.
// ----------------------------------------------------------------------------
module proportional_fair_scheduler #(
  parameter int USER_COUNT = pfs_pkg::USER_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [pfs_pkg::ALPHA_W-1:0]   cfg_wr_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [pfs_pkg::USER_W-1:0]    in_user_index,
  input  logic [pfs_pkg::SINR_W-1:0]    in_sinr_sample,
  input  logic                          in_slot_last,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [pfs_pkg::USER_W-1:0]    out_chosen_user,
  output logic [pfs_pkg::METRIC_W-1:0]  out_chosen_metric
);

  import pfs_pkg::*;

  logic [ALPHA_W-1:0] alpha_r;
  work_t              work_data;
  logic               work_pop;
  logic               work_empty;
  result_t            res_data;
  logic               res_push;
  logic               res_full;
  result_t            out_data;

  // smoothing weight register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_wr_en) begin
      alpha_r <= cfg_wr_data;
    end
  end

  pfs_front #(
    .USER_COUNT (USER_COUNT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_user_index  (in_user_index),
    .in_sinr_sample (in_sinr_sample),
    .in_slot_last   (in_slot_last),
    .work_pop       (work_pop),
    .work_data      (work_data),
    .work_empty     (work_empty)
  );

  pfs_back #(
    .USER_COUNT (USER_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .alpha      (alpha_r),
    .work_pop   (work_pop),
    .work_data  (work_data),
    .work_empty (work_empty),
    .res_push   (res_push),
    .res_data   (res_data),
    .res_full   (res_full)
  );

  // result queue
  pfs_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

  assign out_chosen_user   = out_data.user;
  assign out_chosen_metric = out_data.metric;

endmodule
